// ===== hw/rtl/fifo_or_priority_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the queue block
// Clocked checks that are disabled while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FIFO_OR_PRIORITY_QUEUE_TOP_MACROS_SVH
`define FIFO_OR_PRIORITY_QUEUE_TOP_MACROS_SVH

// Checks a property at every rising edge of i_clk outside of reset.
`define FOPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checks that a condition implies a consequence on the next clock edge.
`define FOPQ_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fopq_pkg.sv =====
// ----------------------------------------------------------------------------
// Queue package
// Entry and cell control types shared by the cell row and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package fopq_pkg;

    localparam int unsigned IdW    = 8;
    localparam int unsigned PriceW = 16;
    localparam int unsigned LenW   = 5;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef struct packed {
        logic [IdW-1:0]    id;
        logic [PriceW-1:0] price;
    } t_entry;

    typedef struct packed {
        logic   enq;
        logic   deq;
        logic   prio;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/fopq_cell.sv =====
// ----------------------------------------------------------------------------
// Queue cell
// Holds one entry; on an enqueue it keeps, takes the new entry or shifts in
// its front neighbor, and on a dequeue it shifts in its rear neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module fopq_cell (
    input  wire logic                  i_clk,
    input  wire fopq_pkg::t_cell_ctrl  i_ctrl,
    input  wire logic                  i_occupied,
    input  wire logic                  i_prior,
    input  wire fopq_pkg::t_entry      i_prev,
    input  wire fopq_pkg::t_entry      i_next,
    output logic                       o_prior,
    output fopq_pkg::t_entry           o_entry
);
    import fopq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   lower;
    logic   hit;

    assign lower   = i_occupied && i_ctrl.prio && (r_entry.price < i_ctrl.new_entry.price);
    assign hit     = !i_occupied || lower;
    assign o_prior = i_prior || hit;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.enq) begin
            if (i_prior) begin
                n_entry = i_prev;
            end else if (hit) begin
                n_entry = i_ctrl.new_entry;
            end
        end else if (i_ctrl.deq) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_or_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// FIFO or priority queue
// Bounded queue of handle and price entries in arrival or highest-price order.
// ----------------------------------------------------------------------------
// The block takes one request beat per clock cycle and returns one result beat
// for each in the next cycle, from an output register. Each request updates all
// cells together because each of the DEPTH cells of the row compares its
// own price with the new one and shifts toward its neighbor at once; the
// insertion point ripples along the row as a single prior-hit signal. The
// input stalls only while a result beat is held and not taken.
`default_nettype none

`include "fifo_or_priority_queue_top_macros.svh"

module fifo_or_priority_queue_top #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // item_id [7:0], price [23:8]
    input  wire logic [23:0] s_axis_tdata,
    // req_type [0]
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // out_item_id [7:0], out_price [23:8], was_empty [24], dropped_full [25],
    // cur_length [30:26], peak_length [35:31], zero [39:36]
    output logic [39:0]      m_axis_tdata,
    // out_valid [0]
    output logic [0:0]       m_axis_tuser
);
    import fopq_pkg::*;

    localparam int unsigned CntW = $clog2(DEPTH + 1);

    logic            r_prio;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic [CntW-1:0] r_peak;
    logic [CntW-1:0] n_peak;
    logic            r_m_valid;
    logic [39:0]     r_m_tdata;
    logic [0:0]      r_m_tuser;

    logic            in_acc;
    logic            is_deq;
    logic            full;
    logic            empty;
    logic            out_hit;
    logic            drop;
    t_entry          new_entry;
    t_entry          front;
    t_cell_ctrl      ctrl;
    logic [31:0]     count_w;
    logic [31:0]     peak_w;

    t_entry          cell_entry [DEPTH];
    logic            cell_prior [DEPTH+1];

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign is_deq        = (s_axis_tuser[0] == REQ_DEQ);
    assign full          = (r_count == CntW'(DEPTH));
    assign empty         = (r_count == '0);
    assign new_entry.id    = s_axis_tdata[7:0];
    assign new_entry.price = s_axis_tdata[23:8];

    assign ctrl.enq       = in_acc && !is_deq && !full;
    assign ctrl.deq       = in_acc && is_deq && !empty;
    assign ctrl.prio      = r_prio;
    assign ctrl.new_entry = new_entry;

    assign out_hit = is_deq && !empty;
    assign drop    = !is_deq && full;
    assign front   = cell_entry[0];

    assign cell_prior[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_entry prev_entry;
            t_entry next_entry;
            if (g == 0) begin : g_first
                assign prev_entry = new_entry;
            end else begin : g_mid
                assign prev_entry = cell_entry[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign next_entry = new_entry;
            end else begin : g_body
                assign next_entry = cell_entry[g+1];
            end
            fopq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (ctrl),
                .i_occupied (CntW'(g) < r_count),
                .i_prior    (cell_prior[g]),
                .i_prev     (prev_entry),
                .i_next     (next_entry),
                .o_prior    (cell_prior[g+1]),
                .o_entry    (cell_entry[g])
            );
        end
    endgenerate

    always_comb begin
        n_count = r_count;
        if (ctrl.enq) begin
            n_count = r_count + 1'b1;
        end else if (ctrl.deq) begin
            n_count = r_count - 1'b1;
        end
        n_peak = (n_count > r_peak) ? n_count : r_peak;
    end

    assign count_w = 32'(n_count);
    assign peak_w  = 32'(n_peak);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio    <= 1'b0;
            r_count   <= '0;
            r_peak    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prio <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_count   <= n_count;
                r_peak    <= n_peak;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_m_tdata[7:0]   <= out_hit ? front.id : '0;
            r_m_tdata[23:8]  <= out_hit ? front.price : '0;
            r_m_tdata[24]    <= is_deq && empty;
            r_m_tdata[25]    <= drop;
            r_m_tdata[30:26] <= count_w[LenW-1:0];
            r_m_tdata[35:31] <= peak_w[LenW-1:0];
            r_m_tdata[39:36] <= '0;
            r_m_tuser[0]     <= out_hit;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

    `FOPQ_ASSERT(a_count_bound, (r_count <= CntW'(DEPTH)), "count exceeds depth")
    `FOPQ_ASSERT(a_peak_ge_count, (r_peak >= r_count), "peak below current count")
    `FOPQ_ASSERT_NEXT(a_deq_shrinks, ctrl.deq, (r_count == $past(r_count) - 1'b1),
        "dequeue did not shrink the queue")
    `FOPQ_ASSERT_NEXT(a_enq_grows, ctrl.enq, (r_count == $past(r_count) + 1'b1),
        "enqueue did not grow the queue")
    `FOPQ_ASSERT_NEXT(a_result_follows, in_acc, (r_m_valid && (!r_m_tuser[0] || !r_m_tdata[24])),
        "missing or inconsistent result beat")

endmodule

`default_nettype wire

// ===== tb/fifo_or_priority_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// Queue block testbench
// Sends enqueue and dequeue beats in arrival and priority order, with random
// gaps and stalls on both streams, and checks every result beat against a
// software copy of the queue that predicts the entry, flags and lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_or_priority_queue_top_test;

    import fopq_pkg::*;

    localparam int unsigned QDEPTH = 16;

    typedef enum int {
        PRICE_ANY,
        PRICE_TIES,
        PRICE_EDGES
    } t_price_style;

    typedef struct packed {
        logic              valid;
        logic [IdW-1:0]    id;
        logic [PriceW-1:0] price;
        logic              empty;
        logic              dropped;
        logic [LenW-1:0]   cur;
        logic [LenW-1:0]   peak;
    } t_queue_result;

    class t_queue_scoreboard;
        t_entry        held[$];
        t_queue_result expected[$];
        logic          mode;
        int unsigned   peak;
        int            errors;

        function new();
            mode   = 1'b0;
            peak   = 0;
            errors = 0;
        endfunction

        function void set_mode(logic m);
            mode = m;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        function void note_request(logic req, t_entry e);
            t_queue_result r;
            int            pos;
            int            i;
            bit            found;
            r     = '0;
            found = 1'b0;
            if (req == REQ_ENQ) begin
                if (held.size() >= QDEPTH) begin
                    r.dropped = 1'b1;
                end else begin
                    pos = held.size();
                    if (mode) begin
                        for (i = 0; i < held.size(); i++) begin
                            if (!found && held[i].price < e.price) begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                    end
                    held.insert(pos, e);
                    if (held.size() > peak) begin
                        peak = held.size();
                    end
                end
            end else begin
                if (held.size() == 0) begin
                    r.empty = 1'b1;
                end else begin
                    r.valid = 1'b1;
                    r.id    = held[0].id;
                    r.price = held[0].price;
                    void'(held.pop_front());
                end
            end
            r.cur  = LenW'(held.size());
            r.peak = LenW'(peak);
            expected.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned seen);
            if (want != seen) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(logic [39:0] data, logic [0:0] user);
            t_queue_result want;
            if (expected.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual tdata %h tuser %b",
                         $time, data, user);
                errors++;
                return;
            end
            want = expected.pop_front();
            compare_field("out_valid", want.valid, user[0]);
            compare_field("out_item_id", want.id, data[7:0]);
            compare_field("out_price", want.price, data[23:8]);
            compare_field("was_empty", want.empty, data[24]);
            compare_field("dropped_full", want.dropped, data[25]);
            compare_field("cur_length", want.cur, data[30:26]);
            compare_field("peak_length", want.peak, data[35:31]);
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic        i_cfg_wdata   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // item_id [7:0], price [23:8]
    logic [23:0] s_axis_tdata  = '0;
    // req_type [0]
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // out_item_id [7:0], out_price [23:8], was_empty [24], dropped_full [25],
    // cur_length [30:26], peak_length [35:31], zero [39:36]
    logic [39:0] m_axis_tdata;
    // out_valid [0]
    logic [0:0]  m_axis_tuser;

    bit calm = 1'b0;

    t_queue_scoreboard board = new();

    fifo_or_priority_queue_top #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PriceW-1:0] pick_price(t_price_style style);
        case (style)
            PRICE_TIES: begin
                return PriceW'($urandom_range(0, 3));
            end
            PRICE_EDGES: begin
                return ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000) ^ PriceW'($urandom_range(0, 1));
            end
            default: begin
                return PriceW'($urandom);
            end
        endcase
    endfunction

    task automatic offer_request(input logic req, input logic [IdW-1:0] id,
                                 input logic [PriceW-1:0] price);
        int     gap;
        t_entry e;
        gap = pick_gap(calm);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {price, id};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        e.id    = id;
        e.price = price;
        board.note_request(req, e);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        wait_results_drained();
        i_cfg_wdata <= m;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_mode(m);
    endtask

    // Result side: random stalls, and a long hold-off after a number of beats
    // so that the block fills up and pushes back on its input.
    initial begin
        int stall_left;
        int hold_left;
        int next_hold;
        int results_seen;
        stall_left   = 0;
        hold_left    = 0;
        next_hold    = 150;
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                board.check_result(m_axis_tdata, m_axis_tuser);
            end
            if (results_seen >= next_hold) begin
                hold_left = 300;
                next_hold = next_hold + 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = pick_gap(calm);
            end
        end
    end

    initial begin
        int           k;
        int           sent;
        int           phase_no;
        int           phase_len;
        int           enq_pct;
        logic         phase_mode;
        logic         req;
        t_price_style style;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        offer_request(REQ_DEQ, 8'h00, 16'h0000);
        offer_request(REQ_ENQ, 8'h00, 16'h0000);
        offer_request(REQ_ENQ, 8'hFF, 16'hFFFF);
        offer_request(REQ_DEQ, 8'hFF, 16'hFFFF);
        offer_request(REQ_DEQ, 8'h00, 16'h0000);
        for (k = 0; k < QDEPTH; k++) begin
            offer_request(REQ_ENQ, IdW'(k), PriceW'((k % 3) * 32767));
        end
        offer_request(REQ_ENQ, 8'hAA, 16'h5555);
        // The held entries are out of price order when priority mode is switched on.
        write_mode(1'b1);
        offer_request(REQ_DEQ, 8'h55, 16'hAAAA);
        offer_request(REQ_ENQ, 8'h55, 16'h8000);
        offer_request(REQ_DEQ, 8'h00, 16'h0000);

        sent     = 0;
        phase_no = 0;
        while (sent < 600) begin
            phase_len  = $urandom_range(20, 60);
            phase_mode = (phase_no < 2) ? phase_no[0] : 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: enq_pct = 30;
                1: enq_pct = 50;
                2: enq_pct = 70;
                default: enq_pct = 90;
            endcase
            style = t_price_style'($urandom_range(0, 2));
            write_mode(phase_mode);
            calm = ($urandom_range(0, 3) == 0);
            for (k = 0; k < phase_len; k++) begin
                req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
                offer_request(req, IdW'($urandom), pick_price(style));
            end
            sent     = sent + phase_len;
            phase_no = phase_no + 1;
        end

        calm = 1'b0;
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/fopq_pkg.sv
hw/rtl/fopq_cell.sv
hw/rtl/fifo_or_priority_queue_top.sv
tb/fifo_or_priority_queue_top_test.sv
